>>> sv/btn_mtc_pkg.sv
// ----------------------------------------------------------------------------
// btn_mtc_pkg
// Shared types and constants for the multi-tap button counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btn_mtc_pkg;

    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned PRESS_W    = 8;
    localparam int unsigned WINDOW_W   = 16;
    localparam int unsigned TAPS_W     = 4;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [PHASE_W-1:0] PHASE_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_WINDOW = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_PRESS  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_WINDOW = 1'd1;

    localparam logic [PRESS_W-1:0]  DEBOUNCE_RESET   = 8'd2;
    localparam logic [WINDOW_W-1:0] TAP_WINDOW_RESET = 16'd300;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [PRESS_W-1:0]  press_ticks;
        logic [WINDOW_W-1:0] window_ticks;
        logic [TAPS_W-1:0]   taps_seen;
    } state_t;

endpackage

>>> sv/btn_mtc_step.sv
// ----------------------------------------------------------------------------
// btn_mtc_step
// Next-state and result logic for one button sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btn_mtc_step (
    input  btn_mtc_pkg::state_t                        cur,
    input  logic                                       button_down,
    input  logic [btn_mtc_pkg::PRESS_W-1:0]            debounce_ticks,
    input  logic [btn_mtc_pkg::WINDOW_W-1:0]           tap_window_ticks,
    output btn_mtc_pkg::state_t                        nxt,
    output logic                                       emit,
    output logic [btn_mtc_pkg::TAPS_W-1:0]             tap_count
);
    import btn_mtc_pkg::*;

    logic [PRESS_W-1:0]  press_inc;
    logic [WINDOW_W-1:0] window_inc;
    logic [TAPS_W-1:0]   taps_inc;

    // saturating increments
    assign press_inc  = (&cur.press_ticks)  ? cur.press_ticks  : cur.press_ticks + 1'b1;
    assign window_inc = (&cur.window_ticks) ? cur.window_ticks : cur.window_ticks + 1'b1;
    assign taps_inc   = (&cur.taps_seen)    ? cur.taps_seen    : cur.taps_seen + 1'b1;

    assign tap_count = cur.taps_seen;

    always_comb begin
        nxt  = cur;
        emit = 1'b0;
        case (cur.phase)
            PHASE_PRESS: begin
                nxt.window_ticks = window_inc;
                if (button_down) begin
                    nxt.press_ticks = press_inc;
                end else begin
                    if (cur.press_ticks >= debounce_ticks) begin
                        nxt.taps_seen    = taps_inc;
                        nxt.window_ticks = '0;
                    end
                    nxt.phase = PHASE_WINDOW;
                end
            end
            PHASE_WINDOW: begin
                nxt.window_ticks = window_inc;
                if (button_down) begin
                    nxt.phase       = PHASE_PRESS;
                    nxt.press_ticks = PRESS_W'(1);
                end else if (window_inc >= tap_window_ticks) begin
                    // window ran out with the button up
                    emit      = 1'b1;
                    nxt.phase = PHASE_IDLE;
                end
            end
            default: begin
                nxt.phase = PHASE_IDLE;
                if (button_down) begin
                    nxt.phase        = PHASE_PRESS;
                    nxt.press_ticks  = PRESS_W'(1);
                    nxt.window_ticks = '0;
                    nxt.taps_seen    = '0;
                end
            end
        endcase
    end

endmodule

>>> sv/button_multi_tap_counter.sv
// ----------------------------------------------------------------------------
// button_multi_tap_counter
// Latency: a result is shown on m_ the cycle after the sample that ends the
// window is transferred. Throughput: one sample per cycle; the state update
// is a single pass of counter logic and the output register frees s_ready.
// s_ready drops only while a result waits with m_ready low.
// Reset (aresetn low, synchronous): idle, counters zero, no result pending,
// debounce 2 ticks, tap window 300 ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_multi_tap_counter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_button_down,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [btn_mtc_pkg::TAPS_W-1:0]         m_tap_count,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [btn_mtc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [btn_mtc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import btn_mtc_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [PRESS_W-1:0]  debounce_reg;
    logic [WINDOW_W-1:0] tap_window_reg;
    logic                m_valid_reg;
    logic [TAPS_W-1:0]   m_tap_count_reg;
    logic                emit;
    logic [TAPS_W-1:0]   step_count;
    logic                s_xfer;

    assign s_ready     = !m_valid_reg || m_ready;
    assign s_xfer      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_tap_count = m_tap_count_reg;
    assign cfg_ready   = 1'b1;

    btn_mtc_step u_step (
        .cur              (state_reg),
        .button_down      (s_button_down),
        .debounce_ticks   (debounce_reg),
        .tap_window_ticks (tap_window_reg),
        .nxt              (state_next),
        .emit             (emit),
        .tap_count        (step_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            tap_window_reg <= TAP_WINDOW_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data[PRESS_W-1:0];
                REG_TAP_WINDOW: tap_window_reg <= cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                state_reg <= state_next;
            end
            // output register: load on a result, clear once transferred
            if (s_xfer && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && emit) begin
            m_tap_count_reg <= step_count;
        end
    end

endmodule

>>> sv/btn_mtc_checker.sv
// ----------------------------------------------------------------------------
// btn_mtc_checker
// Port-level checks for the multi-tap button counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btn_mtc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_button_down,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [btn_mtc_pkg::TAPS_W-1:0]    m_tap_count
);
    import btn_mtc_pkg::*;

    logic held_reg;
    logic fresh_result;

    // result waiting with no transfer in the previous cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
        end else begin
            held_reg <= m_valid && !m_ready;
        end
    end

    // a result that was not already waiting last cycle
    assign fresh_result = m_valid && !held_reg;

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tap_count))
        else $error("result changed while stalled");

    // input side never stalls while the output register is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with no result pending");

    // every new result comes from a sample transfer in the cycle before
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_result |-> $past(s_valid && s_ready))
        else $error("result without a sample transfer");

    // a sequence only ends on a released sample
    a_end_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_result |-> !$past(s_button_down))
        else $error("sequence ended while button down");

endmodule

bind button_multi_tap_counter btn_mtc_checker u_btn_mtc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_button_down (s_button_down),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_tap_count   (m_tap_count)
);
